// ===== sv/segint_pkg.sv =====
// Shared widths and pipeline types for the segment intersection point block.
`timescale 1ns / 1ps
`default_nettype none
package segint_pkg;

   localparam int CoordBits = 16;
   localparam int DiffBits  = CoordBits + 1;
   localparam int ProdBits  = 2 * DiffBits;
   localparam int DenBits   = ProdBits + 1;
   localparam int MagBits   = DenBits - 1;
   localparam int QuoBits   = CoordBits + 1;
   localparam int DvdBits   = MagBits + QuoBits;
   localparam int PipeDepth = QuoBits + 6;

   typedef struct packed {
      logic                  valid;
      logic                  hit;
      logic [MagBits-1:0]    den;
      logic [MagBits-1:0]    rx;
      logic [MagBits-1:0]    ry;
      logic [QuoBits-1:0]    wx;
      logic [QuoBits-1:0]    wy;
      logic                  negx;
      logic                  negy;
      logic [CoordBits-1:0]  ax0;
      logic [CoordBits-1:0]  ay0;
   } cell_type;

endpackage
`default_nettype wire

// ===== sv/segint_div_cell.sv =====
// One restoring-division cell: one quotient bit for each lane.
`timescale 1ns / 1ps
`default_nettype none
module segint_div_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire segint_pkg::cell_type cell_i,
   output      segint_pkg::cell_type cell_o
);

   segint_pkg::cell_type cell_in, cell_ff;
   logic valid_ff;
   logic [segint_pkg::DenBits-1:0] tx, ty, dext;
   logic gex, gey;

   always_comb begin
      dext = {1'b0, cell_i.den};
      tx   = {cell_i.rx, cell_i.wx[segint_pkg::QuoBits-1]};
      ty   = {cell_i.ry, cell_i.wy[segint_pkg::QuoBits-1]};
      gex  = tx >= dext;
      gey  = ty >= dext;
      cell_in    = cell_i;
      cell_in.rx = gex ? segint_pkg::MagBits'(tx - dext) : tx[segint_pkg::MagBits-1:0];
      cell_in.ry = gey ? segint_pkg::MagBits'(ty - dext) : ty[segint_pkg::MagBits-1:0];
      cell_in.wx = {cell_i.wx[segint_pkg::QuoBits-2:0], gex};
      cell_in.wy = {cell_i.wy[segint_pkg::QuoBits-2:0], gey};
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cell_i.valid;
      end
   end

   always_comb begin
      cell_o       = cell_ff;
      cell_o.valid = valid_ff;
   end

endmodule
`default_nettype wire

// ===== sv/segment_intersection_point.sv =====
// Top level: cross products, hit test, scaling and a chain of divider cells.
// One transaction is accepted in every cycle while reset is low; busy only
// mirrors reset. Each result appears on the rsp_ ports for one cycle, marked
// by rsp_valid, after six fixed stages plus one divider cell per quotient
// bit (17 cells); results keep request order and are never held back.
`timescale 1ns / 1ps
`default_nettype none
module segment_intersection_point (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic signed [segint_pkg::CoordBits-1:0] req_ax0,
   input  wire logic signed [segint_pkg::CoordBits-1:0] req_ay0,
   input  wire logic signed [segint_pkg::CoordBits-1:0] req_ax1,
   input  wire logic signed [segint_pkg::CoordBits-1:0] req_ay1,
   input  wire logic signed [segint_pkg::CoordBits-1:0] req_bx0,
   input  wire logic signed [segint_pkg::CoordBits-1:0] req_by0,
   input  wire logic signed [segint_pkg::CoordBits-1:0] req_bx1,
   input  wire logic signed [segint_pkg::CoordBits-1:0] req_by1,
   output      logic        rsp_valid,
   output      logic        rsp_hit,
   output      logic signed [segint_pkg::CoordBits-1:0] rsp_point_x,
   output      logic signed [segint_pkg::CoordBits-1:0] rsp_point_y
);

   localparam int CB = segint_pkg::CoordBits;
   localparam int DB = segint_pkg::DiffBits;
   localparam int PB = segint_pkg::ProdBits;
   localparam int NB = segint_pkg::DenBits;
   localparam int MB = segint_pkg::MagBits;
   localparam int QB = segint_pkg::QuoBits;
   localparam int VB = segint_pkg::DvdBits;

   logic [4:0] vld_ff;

   // stage 1: differences
   logic signed [DB-1:0] dxa_ff, dya_ff, dxb_ff, dyb_ff, ox_ff, oy_ff;
   logic [CB-1:0] ax0_s1_ff, ay0_s1_ff;
   // stage 2: products
   logic signed [PB-1:0] pd1_ff, pd2_ff, pa1_ff, pa2_ff, pb1_ff, pb2_ff;
   logic signed [DB-1:0] dxa_s2_ff, dya_s2_ff;
   logic [CB-1:0] ax0_s2_ff, ay0_s2_ff;
   // stage 3: cross products
   logic signed [NB-1:0] d_ff, na_ff, nb_ff;
   logic signed [DB-1:0] dxa_s3_ff, dya_s3_ff;
   logic [CB-1:0] ax0_s3_ff, ay0_s3_ff;
   // stage 4: normalize and test
   logic signed [NB-1:0] dn_in, nan_in, nbn_in;
   logic hit_in, hit_s4_ff;
   logic [MB-1:0] den_s4_ff, na_s4_ff;
   logic [DB-1:0] mx_s4_ff, my_s4_ff;
   logic negx_s4_ff, negy_s4_ff;
   logic [CB-1:0] ax0_s4_ff, ay0_s4_ff;
   // stage 5: scaled dividends
   logic [VB-1:0] prodx_in, prody_in;
   segint_pkg::cell_type chain [QB+1];
   segint_pkg::cell_type c5_ff;

   // output
   logic hit_ff;
   logic [CB-1:0] px_ff, py_ff;
   logic valid_ff;
   segint_pkg::cell_type last;
   logic [CB-1:0] px_in, py_in;

   function automatic logic [CB-1:0] place(input logic [QB-1:0] q, input logic [MB-1:0] r,
                                           input logic [MB-1:0] den, input logic neg,
                                           input logic [CB-1:0] base);
      logic half;
      logic signed [QB:0] off;
      logic signed [QB:0] sum;
      half = {r, 1'b0} >= {1'b0, den};
      if (!neg) begin
         off = $signed({1'b0, q}) + $signed((QB+1)'(half));
      end else if (half) begin
         off = -$signed({1'b0, q});
      end else if (q == '0) begin
         off = '0;
      end else begin
         off = -($signed({1'b0, q}) - $signed((QB+1)'(1)));
      end
      sum = $signed({{(QB+1-CB){base[CB-1]}}, base}) + off;
      return sum[CB-1:0];
   endfunction

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[3:0], start};
      end
   end

   always_ff @(posedge clock) begin
      dxa_ff    <= DB'(req_ax1) - DB'(req_ax0);
      dya_ff    <= DB'(req_ay1) - DB'(req_ay0);
      dxb_ff    <= DB'(req_bx1) - DB'(req_bx0);
      dyb_ff    <= DB'(req_by1) - DB'(req_by0);
      ox_ff     <= DB'(req_ax0) - DB'(req_bx0);
      oy_ff     <= DB'(req_ay0) - DB'(req_by0);
      ax0_s1_ff <= req_ax0;
      ay0_s1_ff <= req_ay0;

      pd1_ff    <= dxa_ff * dyb_ff;
      pd2_ff    <= dxb_ff * dya_ff;
      pa1_ff    <= dxb_ff * oy_ff;
      pa2_ff    <= dyb_ff * ox_ff;
      pb1_ff    <= dxa_ff * oy_ff;
      pb2_ff    <= dya_ff * ox_ff;
      dxa_s2_ff <= dxa_ff;
      dya_s2_ff <= dya_ff;
      ax0_s2_ff <= ax0_s1_ff;
      ay0_s2_ff <= ay0_s1_ff;

      d_ff      <= NB'(pd1_ff) - NB'(pd2_ff);
      na_ff     <= NB'(pa1_ff) - NB'(pa2_ff);
      nb_ff     <= NB'(pb1_ff) - NB'(pb2_ff);
      dxa_s3_ff <= dxa_s2_ff;
      dya_s3_ff <= dya_s2_ff;
      ax0_s3_ff <= ax0_s2_ff;
      ay0_s3_ff <= ay0_s2_ff;

      hit_s4_ff  <= hit_in;
      den_s4_ff  <= dn_in[MB-1:0];
      na_s4_ff   <= nan_in[MB-1:0];
      mx_s4_ff   <= dxa_s3_ff[DB-1] ? DB'(-dxa_s3_ff) : DB'(dxa_s3_ff);
      my_s4_ff   <= dya_s3_ff[DB-1] ? DB'(-dya_s3_ff) : DB'(dya_s3_ff);
      negx_s4_ff <= dxa_s3_ff[DB-1];
      negy_s4_ff <= dya_s3_ff[DB-1];
      ax0_s4_ff  <= ax0_s3_ff;
      ay0_s4_ff  <= ay0_s3_ff;

      c5_ff.hit  <= hit_s4_ff;
      c5_ff.den  <= den_s4_ff;
      c5_ff.rx   <= prodx_in[VB-1:QB];
      c5_ff.ry   <= prody_in[VB-1:QB];
      c5_ff.wx   <= prodx_in[QB-1:0];
      c5_ff.wy   <= prody_in[QB-1:0];
      c5_ff.negx <= negx_s4_ff;
      c5_ff.negy <= negy_s4_ff;
      c5_ff.ax0  <= ax0_s4_ff;
      c5_ff.ay0  <= ay0_s4_ff;
      c5_ff.valid <= 1'b0;
   end

   always_comb begin
      dn_in  = d_ff[NB-1] ? -d_ff : d_ff;
      nan_in = d_ff[NB-1] ? -na_ff : na_ff;
      nbn_in = d_ff[NB-1] ? -nb_ff : nb_ff;
      hit_in = (d_ff != '0) && !nan_in[NB-1] && !nbn_in[NB-1]
               && (nan_in <= dn_in) && (nbn_in <= dn_in);
      prodx_in = VB'(na_s4_ff) * VB'(mx_s4_ff);
      prody_in = VB'(na_s4_ff) * VB'(my_s4_ff);
   end

   always_comb begin
      chain[0]       = c5_ff;
      chain[0].valid = vld_ff[4];
   end

   for (genvar i = 0; i < QB; i++) begin : g_cell
      segint_div_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .cell_i (chain[i]),
         .cell_o (chain[i+1])
      );
   end

   always_comb begin
      last  = chain[QB];
      px_in = place(last.wx, last.rx, last.den, last.negx, last.ax0);
      py_in = place(last.wy, last.ry, last.den, last.negy, last.ay0);
   end

   always_ff @(posedge clock) begin
      hit_ff <= last.hit;
      px_ff  <= last.hit ? px_in : '0;
      py_ff  <= last.hit ? py_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= last.valid;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_hit     = hit_ff;
   assign rsp_point_x = px_ff;
   assign rsp_point_y = py_ff;

endmodule
`default_nettype wire

// ===== sv/segint_checker.sv =====
// Port-level checker for the segment intersection point block.
`timescale 1ns / 1ps
`default_nettype none
module segint_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic rsp_hit,
   input wire logic [segint_pkg::CoordBits-1:0] rsp_point_x,
   input wire logic [segint_pkg::CoordBits-1:0] rsp_point_y
);

   a_latency : assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##(segint_pkg::PipeDepth) rsp_valid)
      else $error("transaction result missing");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, segint_pkg::PipeDepth))
      else $error("result without transaction");

   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_point_x == '0 && rsp_point_y == '0)
      else $error("miss with nonzero point");

   a_busy : assert property (@(posedge clock) busy == reset)
      else $error("busy outside reset");

endmodule

bind segment_intersection_point segint_checker u_segint_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_hit     (rsp_hit),
   .rsp_point_x (rsp_point_x),
   .rsp_point_y (rsp_point_y)
);
`default_nettype wire

// ===== tb/sv/tb_segment_intersection_point.sv =====
// Testbench for the segment intersection point block: directed and random checks.
`timescale 1ns / 1ps
`default_nettype none
module tb_segment_intersection_point;

   localparam int WatchdogLimit = 4000;
   localparam int DrainCycles   = 40;

   typedef logic signed [segint_pkg::CoordBits-1:0] coord_type;

   typedef struct {
      logic      hit;
      coord_type px;
      coord_type py;
   } crossing_type;

   logic      clock;
   logic      reset;
   logic      start;
   logic      busy;
   coord_type req_ax0, req_ay0, req_ax1, req_ay1;
   coord_type req_bx0, req_by0, req_bx1, req_by1;
   logic      rsp_valid;
   logic      rsp_hit;
   coord_type rsp_point_x, rsp_point_y;

   crossing_type pending_crossings[$];
   int           error_count;
   int           idle_cycles;
   bit           timed_out;

   segment_intersection_point dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_ax0(req_ax0), .req_ay0(req_ay0), .req_ax1(req_ax1), .req_ay1(req_ay1),
      .req_bx0(req_bx0), .req_by0(req_by0), .req_bx1(req_bx1), .req_by1(req_by1),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // trunc(t*d/den + 1/2), 0 <= t <= den, den > 0
   function automatic longint half_step_offset(longint t, longint den, longint d);
      longint num;
      longint q;
      num = 2 * t * d + den;
      q = num / (2 * den);
      return q;
   endfunction

   function automatic crossing_type predict_crossing(coord_type ax0, coord_type ay0,
                                                     coord_type ax1, coord_type ay1,
                                                     coord_type bx0, coord_type by0,
                                                     coord_type bx1, coord_type by1);
      crossing_type c;
      longint dxa, dya, dxb, dyb, ox, oy, den, na, nb, px, py;
      dxa = longint'(ax1) - ax0;
      dya = longint'(ay1) - ay0;
      dxb = longint'(bx1) - bx0;
      dyb = longint'(by1) - by0;
      ox  = longint'(ax0) - bx0;
      oy  = longint'(ay0) - by0;
      den = dxa * dyb - dxb * dya;
      na  = dxb * oy - dyb * ox;
      nb  = dxa * oy - dya * ox;
      c.hit = 1'b0;
      c.px  = '0;
      c.py  = '0;
      if (den == 0) return c;
      if (den < 0) begin
         den = -den;
         na  = -na;
         nb  = -nb;
      end
      if (na < 0 || nb < 0 || na > den || nb > den) return c;
      px = ax0 + half_step_offset(na, den, dxa);
      py = ay0 + half_step_offset(na, den, dya);
      c.hit = 1'b1;
      c.px  = px[segint_pkg::CoordBits-1:0];
      c.py  = py[segint_pkg::CoordBits-1:0];
      return c;
   endfunction

   // |t*d| <= 2^34 * 2^17 = 2^51, so 2*t*d + den fits in 64 bits.

   task automatic idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return;
      start <= 1'b0;
      if (r < 95) repeat ($urandom_range(1, 3)) @(negedge clock);
      else repeat ($urandom_range(10, 40)) @(negedge clock);
   endtask

   task automatic send_segments(coord_type ax0, coord_type ay0, coord_type ax1,
                                coord_type ay1, coord_type bx0, coord_type by0,
                                coord_type bx1, coord_type by1, bit with_gaps = 1);
      if (with_gaps) idle_gap();
      start   <= 1'b1;
      req_ax0 <= ax0; req_ay0 <= ay0; req_ax1 <= ax1; req_ay1 <= ay1;
      req_bx0 <= bx0; req_by0 <= by0; req_bx1 <= bx1; req_by1 <= by1;
      do @(posedge clock); while (busy);
      pending_crossings.push_back(
         predict_crossing(ax0, ay0, ax1, ay1, bx0, by0, bx1, by1));
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_crossings.size() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin
      crossing_type exp_c;
      if (!reset && rsp_valid) begin
         if (pending_crossings.size() == 0) begin
            $display("%0t: unexpected transaction hit=%0b x=%0d y=%0d",
                     $time, rsp_hit, rsp_point_x, rsp_point_y);
            error_count++;
         end else begin
            exp_c = pending_crossings.pop_front();
            if (rsp_hit !== exp_c.hit || rsp_point_x !== exp_c.px
                || rsp_point_y !== exp_c.py) begin
               $display("%0t: mismatch expected hit=%0b x=%0d y=%0d actual hit=%0b x=%0d y=%0d",
                        $time, exp_c.hit, exp_c.px, exp_c.py,
                        rsp_hit, rsp_point_x, rsp_point_y);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit && !timed_out) begin
         timed_out = 1'b1;
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic coord_type rand_coord(int span);
      if (span <= 0) return coord_type'($urandom);
      return coord_type'($urandom_range(0, 2 * span) - span);
   endfunction

   task automatic test_extremes();
      coord_type mx, mn;
      mx = 16'sh7fff;
      mn = 16'sh8000;
      // crossing diagonals across full range
      send_segments(mn, mn, mx, mx, mn, mx, mx, mn);
      send_segments(mx, mx, mn, mn, mx, mn, mn, mx);
      send_segments(mn, 0, mx, 0, 0, mn, 0, mx);
      send_segments(mx, mn, mn, mx, mn, mn, mx, mx);
      // parallel and degenerate
      send_segments(0, 0, 10, 10, 0, 1, 10, 11);
      send_segments(0, 0, 10, 10, 2, 2, 20, 20);
      send_segments(5, 5, 5, 5, 0, 0, 9, 9);
      send_segments(0, 0, 0, 0, 0, 0, 0, 0);
      // touching at endpoints, and a miss just past one end
      send_segments(0, 0, 10, 0, 10, 0, 10, 10);
      send_segments(0, 0, 10, 0, 0, 0, 0, 10);
      send_segments(0, 0, 10, 0, 11, -5, 11, 5);
      // half-step rounding, both signs
      send_segments(0, 0, 1, 1, 0, 1, 1, 0);
      send_segments(0, 0, -1, -1, 0, -1, -1, 0);
      send_segments(0, 0, -3, 0, -1, -1, -2, 1);
      send_segments(0, 0, 3, -3, 0, -3, 3, 0);
      // miss beyond an end of A and of B, then B ending on A at full range
      send_segments(0, 0, 4, 0, 5, -1, 6, 1);
      send_segments(0, 0, 4, 0, 2, 1, 2, 3);
      send_segments(mx, mx, mx, mn, mn, mx, mx, 0);
   endtask

   task automatic test_random_pairs(int count);
      coord_type ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, cx, cy;
      int span, kind;
      repeat (count) begin
         kind = $urandom_range(0, 9);
         span = (kind < 3) ? 0 : (kind < 6) ? 100 : 2000;
         if (kind >= 3 && kind < 9) begin
            // build B through a point on A so most pairs cross
            cx  = rand_coord(span);
            cy  = rand_coord(span);
            ax0 = cx - rand_coord(span / 2); ay0 = cy - rand_coord(span / 2);
            ax1 = coord_type'(2 * cx - ax0); ay1 = coord_type'(2 * cy - ay0);
            bx0 = cx - rand_coord(span / 2); by0 = cy - rand_coord(span / 2);
            bx1 = coord_type'(2 * cx - bx0 + rand_coord(3));
            by1 = coord_type'(2 * cy - by0 + rand_coord(3));
         end else begin
            ax0 = rand_coord(span); ay0 = rand_coord(span);
            ax1 = rand_coord(span); ay1 = rand_coord(span);
            bx0 = rand_coord(span); by0 = rand_coord(span);
            bx1 = rand_coord(span); by1 = rand_coord(span);
         end
         send_segments(ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
      end
   endtask

   task automatic test_back_to_back(int count);
      repeat (count)
         send_segments(rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0),
                       rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0), 0);
   endtask

   initial begin
      error_count = 0;
      idle_cycles = 0;
      timed_out   = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_ax0 = '0; req_ay0 = '0; req_ax1 = '0; req_ay1 = '0;
      req_bx0 = '0; req_by0 = '0; req_bx1 = '0; req_by1 = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_extremes();
      wait_for_drain();
      test_random_pairs(300);
      wait_for_drain();
      test_back_to_back(60);
      test_random_pairs(170);
      wait_for_drain();
      repeat (DrainCycles) @(negedge clock);
      if (error_count == 0 && pending_crossings.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire
